@@ rtl/core/tdp_pkg.sv @@
package tdp_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_ACC_WIDTH  = 48;

    localparam int GAIN_W      = 31;
    localparam int WEIGHT_W    = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int SLICE_W     = 32;
    localparam int TERM_LIM_SH = 60;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN        = 3'd0,
        CFG_INTEG_GAIN_DT    = 3'd1,
        CFG_DERIV_GAIN_RATE  = 3'd2,
        CFG_REF_WEIGHT_PROP  = 3'd3,
        CFG_REF_WEIGHT_DERIV = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain_dt;
        logic [GAIN_W-1:0]   deriv_gain_rate;
        logic [WEIGHT_W-1:0] ref_weight_prop;
        logic [WEIGHT_W-1:0] ref_weight_deriv;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_ESUM,
        OP_MUL,
        OP_POST_RB,
        OP_POST_RG,
        OP_DIFF,
        OP_TERM,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        A_R,
        A_PD,
        A_ESUM,
        A_DD
    } t_asel;

    typedef enum logic [2:0] {
        B_PROP,
        B_INTEG,
        B_DERIV,
        B_BETA,
        B_GAMMA
    } t_bsel;

    typedef enum logic [1:0] {
        H_NONE,
        H_INPUT,
        H_MUL,
        H_OUT
    } t_hold;

    typedef logic [3:0] t_upc;

    typedef struct packed {
        t_op   op;
        t_asel asel;
        t_bsel bsel;
        t_hold hold_on;
        logic  jump;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic mul_last;
        logic out_busy;
    } t_stat;

    localparam t_upc UPC_IDLE    = 4'd0;
    localparam t_upc UPC_ESUM    = 4'd1;
    localparam t_upc UPC_MUL_RB  = 4'd2;
    localparam t_upc UPC_POST_RB = 4'd3;
    localparam t_upc UPC_MUL_RG  = 4'd4;
    localparam t_upc UPC_POST_RG = 4'd5;
    localparam t_upc UPC_DIFF    = 4'd6;
    localparam t_upc UPC_MUL_P   = 4'd7;
    localparam t_upc UPC_TERM_P  = 4'd8;
    localparam t_upc UPC_MUL_I   = 4'd9;
    localparam t_upc UPC_TERM_I  = 4'd10;
    localparam t_upc UPC_MUL_D   = 4'd11;
    localparam t_upc UPC_TERM_D  = 4'd12;
    localparam t_upc UPC_EMIT    = 4'd13;

    // control store: one word per step
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w.op      = OP_NOP;
        w.asel    = A_R;
        w.bsel    = B_PROP;
        w.hold_on = H_NONE;
        w.jump    = 1'b0;
        w.target  = UPC_IDLE;
        case (pc)
            UPC_IDLE: begin
                w.op      = OP_LOAD;
                w.hold_on = H_INPUT;
            end
            UPC_ESUM:    w.op = OP_ESUM;
            UPC_MUL_RB: begin
                w.op      = OP_MUL;
                w.asel    = A_R;
                w.bsel    = B_BETA;
                w.hold_on = H_MUL;
            end
            UPC_POST_RB: w.op = OP_POST_RB;
            UPC_MUL_RG: begin
                w.op      = OP_MUL;
                w.asel    = A_R;
                w.bsel    = B_GAMMA;
                w.hold_on = H_MUL;
            end
            UPC_POST_RG: w.op = OP_POST_RG;
            UPC_DIFF:    w.op = OP_DIFF;
            UPC_MUL_P: begin
                w.op      = OP_MUL;
                w.asel    = A_PD;
                w.bsel    = B_PROP;
                w.hold_on = H_MUL;
            end
            UPC_TERM_P:  w.op = OP_TERM;
            UPC_MUL_I: begin
                w.op      = OP_MUL;
                w.asel    = A_ESUM;
                w.bsel    = B_INTEG;
                w.hold_on = H_MUL;
            end
            UPC_TERM_I:  w.op = OP_TERM;
            UPC_MUL_D: begin
                w.op      = OP_MUL;
                w.asel    = A_DD;
                w.bsel    = B_DERIV;
                w.hold_on = H_MUL;
            end
            UPC_TERM_D:  w.op = OP_TERM;
            UPC_EMIT: begin
                w.op      = OP_EMIT;
                w.hold_on = H_OUT;
                w.jump    = 1'b1;
                w.target  = UPC_IDLE;
            end
            default: begin
                w.jump   = 1'b1;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/tdp_mul.sv @@
module tdp_mul
    import tdp_pkg::*;
#(
    parameter int NCH = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [NCH*SLICE_W-1:0]      i_a,
    input  logic [GAIN_W-1:0]           i_b,
    output logic [NCH*SLICE_W+SLICE_W-1:0] o_prod,
    output logic                        o_last
);

    localparam int MXW = NCH * SLICE_W;
    localparam int PW  = MXW + SLICE_W;
    localparam int CW  = $clog2(NCH + 1);

    logic [CW-1:0]              r_chunk;
    logic signed [2*SLICE_W-1:0] r_pp;
    logic [PW-1:0]              r_acc;

    logic [SLICE_W-1:0]          slice;
    logic                        top;
    logic signed [SLICE_W:0]     a_ext;
    logic signed [GAIN_W:0]      b_ext;
    logic signed [2*SLICE_W:0]   pp_full;
    logic [PW-1:0]               pp_ext;

    // slices go most significant first; only the top one carries the sign
    always_comb begin
        slice = '0;
        top   = 1'b0;
        for (int j = 0; j < NCH; j++) begin
            if (r_chunk == CW'(j)) begin
                slice = i_a[(NCH-1-j)*SLICE_W +: SLICE_W];
                top   = (j == 0);
            end
        end
    end

    assign a_ext   = $signed({top & slice[SLICE_W-1], slice});
    assign b_ext   = $signed({1'b0, i_b});
    assign pp_full = a_ext * b_ext;
    assign pp_ext  = PW'(r_pp);
    assign o_last  = (r_chunk == CW'(NCH));
    assign o_prod  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_en) begin
            r_chunk <= o_last ? '0 : r_chunk + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp <= pp_full[2*SLICE_W-1:0];
            if (r_chunk == CW'(1)) begin
                r_acc <= pp_ext;
            end else if (r_chunk != '0) begin
                r_acc <= {r_acc[PW-SLICE_W-1:0], SLICE_W'(0)} + pp_ext;
            end
        end
    end

endmodule

@@ rtl/core/tdp_dp.sv @@
module tdp_dp
    import tdp_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int ACC_WIDTH  = DEF_ACC_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_uword                       i_uword,
    input  t_cfg                         i_cfg,
    input  logic                         i_in_valid,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_measured,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic signed [DATA_WIDTH-1:0] o_drive,
    output logic                         o_clipped,
    output t_stat                        o_stat
);

    localparam int DW  = DATA_WIDTH;
    localparam int AW  = ACC_WIDTH;
    localparam int EW  = DW + 1;
    localparam int SW  = ((AW > EW) ? AW : EW) + 1;
    localparam int DDW = DW + 4;
    localparam int MAW = (AW > DDW) ? AW : DDW;
    localparam int NCH = (MAW + SLICE_W - 1) / SLICE_W;
    localparam int MXW = NCH * SLICE_W;
    localparam int PW  = MXW + SLICE_W;
    localparam int TW  = TERM_LIM_SH + 2;
    localparam int USW = TW + 1;

    localparam logic signed [PW-1:0] TLIM   = PW'(64'sd1 <<< TERM_LIM_SH);
    localparam logic signed [PW-1:0] TLIM_N = -TLIM;

    logic signed [DW-1:0]  r_r, r_y, r_rg;
    logic signed [DW-1:0]  r_wh0, r_wh1, r_mh0, r_mh1;
    logic signed [EW-1:0]  r_pd;
    logic signed [AW-1:0]  r_esum;
    logic signed [DDW-1:0] r_dd;
    logic signed [USW-1:0] r_usum;
    logic                  r_hit;
    logic                  r_out_valid;
    logic signed [DW-1:0]  r_drive;
    logic                  r_clipped;

    logic signed [EW-1:0]  err;
    logic signed [SW-1:0]  esum_sum;
    logic                  esum_ovf;
    logic signed [AW-1:0]  esum_sat;
    logic signed [DDW-1:0] dmeas_neg;
    logic signed [DDW-1:0] dref;
    logic signed [MXW-1:0] mul_a;
    logic [GAIN_W-1:0]     mul_b;
    logic [PW-1:0]         mul_prod;
    logic                  mul_last;
    logic signed [PW-1:0]  prod_s;
    logic signed [PW-1:0]  q;
    logic signed [TW-1:0]  term;
    logic                  term_ovf;
    logic signed [DW-1:0]  term_dw;
    logic                  drive_ovf;
    logic signed [DW-1:0]  drive_sat;
    logic                  out_busy;
    logic                  emit;

    assign err      = EW'(r_r) - EW'(r_y);
    assign esum_sum = SW'(r_esum) + SW'(err);
    assign esum_ovf = !((&esum_sum[SW-1:AW-1]) || !(|esum_sum[SW-1:AW-1]));
    assign esum_sat = esum_ovf ? {esum_sum[SW-1], {(AW-1){~esum_sum[SW-1]}}}
                               : esum_sum[AW-1:0];

    // negated three-point (second-order accurate) backward difference of the measurement
    assign dmeas_neg = (DDW'(r_mh0) <<< 2) - DDW'(r_y) - (DDW'(r_y) <<< 1) - DDW'(r_mh1);
    assign dref      = DDW'(r_rg) + (DDW'(r_rg) <<< 1) - (DDW'(r_wh0) <<< 2) + DDW'(r_wh1);

    always_comb begin
        case (i_uword.asel)
            A_R:     mul_a = MXW'(r_r);
            A_PD:    mul_a = MXW'(r_pd);
            A_ESUM:  mul_a = MXW'(r_esum);
            A_DD:    mul_a = MXW'(r_dd);
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_uword.bsel)
            B_PROP:  mul_b = i_cfg.prop_gain;
            B_INTEG: mul_b = i_cfg.integ_gain_dt;
            B_DERIV: mul_b = i_cfg.deriv_gain_rate;
            B_BETA:  mul_b = GAIN_W'(i_cfg.ref_weight_prop);
            B_GAMMA: mul_b = GAIN_W'(i_cfg.ref_weight_deriv);
            default: mul_b = '0;
        endcase
    end

    tdp_mul #(
        .NCH (NCH)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_uword.op == OP_MUL),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_prod  (mul_prod),
        .o_last  (mul_last)
    );

    // floor shift, then clamp each term to +-2^60
    assign prod_s = $signed(mul_prod);
    assign q      = prod_s >>> FRAC_BITS;

    always_comb begin
        if (q > TLIM) begin
            term = TW'(TLIM);
        end else if (q < TLIM_N) begin
            term = TW'(TLIM_N);
        end else begin
            term = TW'(q);
        end
    end

    assign term_ovf  = !((&term[TW-1:DW-1]) || !(|term[TW-1:DW-1]));
    assign term_dw   = term_ovf ? {term[TW-1], {(DW-1){~term[TW-1]}}} : term[DW-1:0];
    assign drive_ovf = !((&r_usum[USW-1:DW-1]) || !(|r_usum[USW-1:DW-1]));
    assign drive_sat = drive_ovf ? {r_usum[USW-1], {(DW-1){~r_usum[USW-1]}}}
                                 : r_usum[DW-1:0];

    assign out_busy = r_out_valid && !i_out_ready;
    assign emit     = (i_uword.op == OP_EMIT) && !out_busy;

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum <= '0;
            r_wh0  <= '0;
            r_wh1  <= '0;
            r_mh0  <= '0;
            r_mh1  <= '0;
        end else begin
            case (i_uword.op)
                OP_ESUM: begin
                    r_esum <= esum_sat;
                    r_mh1  <= r_mh0;
                    r_mh0  <= r_y;
                end
                OP_DIFF: begin
                    r_wh1 <= r_wh0;
                    r_wh0 <= r_rg;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    r_r <= i_setpoint;
                    r_y <= i_measured;
                end
            end
            OP_ESUM: begin
                r_hit  <= esum_ovf;
                r_usum <= '0;
                r_dd   <= dmeas_neg;
            end
            OP_POST_RB: r_pd   <= EW'(term_dw) - EW'(r_y);
            OP_POST_RG: r_rg   <= term_dw;
            OP_DIFF:    r_dd   <= r_dd + dref;
            OP_TERM:    r_usum <= r_usum + USW'(term);
            default: ;
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_drive   <= drive_sat;
            r_clipped <= r_hit | drive_ovf;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_drive;
    assign o_clipped       = r_clipped;
    assign o_stat.in_valid = i_in_valid;
    assign o_stat.mul_last = mul_last;
    assign o_stat.out_busy = out_busy;

endmodule

@@ rtl/core/tdp_seq.sv @@
module tdp_seq
    import tdp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stat  i_stat,
    output t_uword o_uword
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword uword;
    logic   stay;

    assign uword = ucode_rom(r_pc);

    always_comb begin
        case (uword.hold_on)
            H_INPUT: stay = !i_stat.in_valid;
            H_MUL:   stay = !i_stat.mul_last;
            H_OUT:   stay = i_stat.out_busy;
            default: stay = 1'b0;
        endcase
    end

    always_comb begin
        if (stay) begin
            n_pc = r_pc;
        end else if (uword.jump) begin
            n_pc = uword.target;
        end else begin
            n_pc = r_pc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UPC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = uword;

endmodule

@@ rtl/core/two_dof_pid_controller.sv @@
// Channel  Direction  Handshake                  Payload
// in       sink       i_in_valid / o_in_ready    i_setpoint, i_measured
// out      source     o_out_valid / i_out_ready  o_drive, o_clipped
// cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A word is accepted only at the load step, so the next word is not taken until the
// last one has been emitted. All five products are made on the single shared 33x32
// multiplier, one 32-bit slice per cycle and then the last add, over N slices per
// product, where N = ceil(max(ACC_WIDTH, DATA_WIDTH+4) / 32).
// Reset clears the gains, the weights (beta to one), the error sum and history.
// A full output register that is not taken holds the sequencer at its last step.
module two_dof_pid_controller
    import tdp_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int ACC_WIDTH  = DEF_ACC_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_measured,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_drive,
    output logic                         o_clipped,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_cfg   r_cfg;
    t_uword uword;
    t_stat  stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (uword.op == OP_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain        <= '0;
            r_cfg.integ_gain_dt    <= '0;
            r_cfg.deriv_gain_rate  <= '0;
            r_cfg.ref_weight_prop  <= WEIGHT_ONE;
            r_cfg.ref_weight_deriv <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:        r_cfg.prop_gain        <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN_DT:    r_cfg.integ_gain_dt    <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN_RATE:  r_cfg.deriv_gain_rate  <= i_cfg_data[GAIN_W-1:0];
                CFG_REF_WEIGHT_PROP:  r_cfg.ref_weight_prop  <= i_cfg_data[WEIGHT_W-1:0];
                CFG_REF_WEIGHT_DERIV: r_cfg.ref_weight_deriv <= i_cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    tdp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uword (uword)
    );

    tdp_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .ACC_WIDTH  (ACC_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (uword),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_drive     (o_drive),
        .o_clipped   (o_clipped),
        .o_stat      (stat)
    );

endmodule
